@@ sv/u2h_pkg.sv @@
// shared types, character constants and hex helper for the utf-8 to html entity converter
package u2h_pkg;

    // what one decoded input byte asks the emitter to send
    typedef enum logic [1:0]
    {
        JOB_ASCII,
        JOB_BAD,
        JOB_REF
    } job_kind_t;

    // one pending output run; code holds the ascii byte for JOB_ASCII
    typedef struct packed
    {
        job_kind_t   kind;
        logic [20:0] code;
        logic [2:0]  ndig;
    } job_t;

    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic [2:0] NDIG_MIN = 3'd4;
    localparam logic [2:0] NDIG_MID = 3'd5;
    localparam logic [2:0] NDIG_MAX = 3'd6;

    // uppercase hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        if (nib < 4'd10)
        begin
            hex_char = wide + 8'h30;
        end
        else
        begin
            hex_char = wide + 8'h37;
        end
    endfunction

endpackage

@@ sv/u2h_decode.sv @@
// utf-8 sequence decoder: holds the open sequence state and turns each byte into a job
module u2h_decode
    import u2h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] byte_in,
    output job_t       job,
    output logic       job_hit
);

    logic [1:0]  bytes_left_reg;
    logic [1:0]  bytes_left_next;
    logic [20:0] code_accum_reg;
    logic [20:0] code_accum_next;
    logic [20:0] cont_code;

    assign cont_code = {code_accum_reg[14:0], byte_in[5:0]};

    // sort the byte against the open sequence
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        code_accum_next = code_accum_reg;
        job_hit         = 1'b0;
        job.kind        = JOB_ASCII;
        job.code        = {13'b0, byte_in};
        job.ndig        = NDIG_MIN;
        if (bytes_left_reg != 2'd0)
        begin
            code_accum_next = cont_code;
            bytes_left_next = bytes_left_reg - 2'd1;
            if (bytes_left_reg == 2'd1)
            begin
                job_hit   = 1'b1;
                job.kind  = JOB_REF;
                job.code  = cont_code;
                if (cont_code[20])
                begin
                    job.ndig = NDIG_MAX;
                end
                else if (cont_code[19:16] != 4'd0)
                begin
                    job.ndig = NDIG_MID;
                end
            end
        end
        else if (!byte_in[7])
        begin
            job_hit = 1'b1;
        end
        else if (byte_in[7:4] == 4'hF)
        begin
            code_accum_next = {18'b0, byte_in[2:0]};
            bytes_left_next = 2'd3;
        end
        else if (byte_in[7:5] == 3'b111)
        begin
            code_accum_next = {17'b0, byte_in[3:0]};
            bytes_left_next = 2'd2;
        end
        else if (byte_in[7:6] == 2'b11)
        begin
            code_accum_next = {16'b0, byte_in[4:0]};
            bytes_left_next = 2'd1;
        end
        else
        begin
            job_hit  = 1'b1;
            job.kind = JOB_BAD;
            job.code = 21'd0;
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 2'd0;
            code_accum_reg <= 21'd0;
        end
        else if (accept)
        begin
            bytes_left_reg <= bytes_left_next;
            code_accum_reg <= code_accum_next;
        end
    end

endmodule

@@ sv/u2h_emit.sv @@
// character serializer: walks one job and drives the output register
module u2h_emit
    import u2h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_take,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // char_out[7:0]
    output logic       m_tuser,   // bad_lead
    output logic       m_tlast
);

    logic       cur_valid_reg;
    logic       cur_valid_next;
    job_t       cur_reg;
    job_t       cur_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;

    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;

    logic       out_free;
    logic       cur_fire;
    logic       cur_last;
    logic       cur_bad;
    logic [7:0] cur_char;
    logic [3:0] last_idx;
    logic [3:0] pos_wide;
    logic [3:0] nib;

    assign out_free = !m_tvalid_reg || m_tready;
    assign cur_fire = cur_valid_reg && out_free;
    assign last_idx = {1'b0, cur_reg.ndig} + 4'd2;
    assign pos_wide = {1'b0, cur_reg.ndig} + 4'd1 - idx_reg;

    // nibble of the code point for the current digit, most significant first
    always_comb
    begin
        case (pos_wide)
            4'd0:    nib = cur_reg.code[3:0];
            4'd1:    nib = cur_reg.code[7:4];
            4'd2:    nib = cur_reg.code[11:8];
            4'd3:    nib = cur_reg.code[15:12];
            4'd4:    nib = cur_reg.code[19:16];
            4'd5:    nib = {3'b000, cur_reg.code[20]};
            default: nib = 4'd0;
        endcase
    end

    // character for the current position of the job
    always_comb
    begin
        cur_bad  = 1'b0;
        cur_last = 1'b1;
        cur_char = 8'h00;
        case (cur_reg.kind)
            JOB_ASCII:
            begin
                cur_char = cur_reg.code[7:0];
            end
            JOB_BAD:
            begin
                cur_bad = 1'b1;
            end
            JOB_REF:
            begin
                cur_last = (idx_reg == last_idx);
                if (idx_reg == 4'd0)
                begin
                    cur_char = CHAR_AMP;
                end
                else if (idx_reg == 4'd1)
                begin
                    cur_char = CHAR_HASH;
                end
                else if (cur_last)
                begin
                    cur_char = CHAR_SEMI;
                end
                else
                begin
                    cur_char = hex_char(nib);
                end
            end
            default:
            begin
                cur_char = 8'h00;
            end
        endcase
    end

    assign job_take = job_valid && (!cur_valid_reg || (cur_fire && cur_last));

    // job and position bookkeeping
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        if (job_take)
        begin
            cur_valid_next = 1'b1;
            cur_next       = job;
            idx_next       = 4'd0;
        end
        else if (cur_fire && cur_last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (cur_fire)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    // output beat valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cur_fire)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cur_fire)
        begin
            m_tdata_reg <= cur_char;
            m_tuser_reg <= cur_bad;
            m_tlast_reg <= cur_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // single-beat jobs never move past the first position
    a_single_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && cur_reg.kind != JOB_REF |-> idx_reg == 4'd0)
        else $error("single-beat job has nonzero position");

    // a reference never runs past its closing semicolon
    a_ref_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && cur_reg.kind == JOB_REF |-> idx_reg <= last_idx)
        else $error("reference position beyond last character");

    // an error beat is a lone zero beat
    a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tuser_reg |-> m_tlast_reg && m_tdata_reg == 8'h00)
        else $error("error beat is not a lone zero beat");

    // a taken job starts at its first character
    a_take_start: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> cur_valid_reg && idx_reg == 4'd0)
        else $error("taken job did not start at position zero");

endmodule

@@ sv/utf8_to_html_entity.sv @@
// utf-8 to html numeric character reference converter, top level
// first beat path: job slot, then serializer job register, then output register
// throughput: one result beat per cycle while m_tready is high; a byte produces as many beats
//   as its job needs (1 for ascii or a stray continuation, 7 to 9 for a completed sequence)
// lead and middle bytes produce no beat and are taken one per cycle while the job slot is free
// reset: asynchronous active low; clears the open sequence, the job slot and the output beat
module utf8_to_html_entity
    import u2h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // byte_in[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // char_out[7:0]
    output logic       m_tuser,   // bad_lead
    output logic       m_tlast
);

    logic accept;
    logic job_hit;
    logic job_take;
    job_t dec_job;
    logic job_valid_reg;
    logic job_valid_next;
    job_t job_reg;

    assign s_tready = !job_valid_reg || job_take;
    assign accept   = s_tvalid && s_tready;

    u2h_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (s_tdata),
        .job     (dec_job),
        .job_hit (job_hit)
    );

    // job slot between decoder and serializer
    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (accept && job_hit)
        begin
            job_valid_next = 1'b1;
        end
        else if (job_take)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && job_hit)
        begin
            job_reg <= dec_job;
        end
    end

    u2h_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid_reg),
        .job       (job_reg),
        .job_take  (job_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
